// File: design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the source token scanner
// Token kinds, scan modes, the keyword table and the character classes.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int unsigned PREFIX_DEPTH = 11;
    localparam int unsigned PIW          = $clog2(PREFIX_DEPTH);
    localparam int unsigned KW_COUNT     = 18;
    localparam int unsigned FIFO_DEPTH   = 4;

    localparam logic [5:0] KIND_END      = 6'd0;
    localparam logic [5:0] KIND_ERROR    = 6'd1;
    localparam logic [5:0] KIND_NONE     = 6'd0;
    localparam logic [5:0] KIND_COMMENT  = 6'd15;
    localparam logic [5:0] KIND_INTEGER  = 6'd16;
    localparam logic [5:0] KIND_NAME     = 6'd17;
    localparam logic [5:0] KIND_FIRST_KW = 6'd18;

    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_NUL      = 2'd1;
    localparam logic [1:0] FAULT_CAPACITY = 2'd2;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_SLASH   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_INTEGER = 5'b01000,
        MODE_NAME    = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start_offset;
        logic [31:0] end_offset;
        logic [10:0] text_length;
        logic [1:0]  fault;
        logic        last_result;
    } result_t;

    // Keyword text is right-justified: the last character sits in byte 0.
    typedef logic [PREFIX_DEPTH-1:0][7:0] kw_text_t;

    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        "out", "class", "module", "static", "sealed", "public",
        "extends", "private", "foreign", "override", "abstract", "protected",
        "namespace", "structure", "implements", "destructor", "constructor",
        "enumeration"
    };

    localparam int unsigned KW_LEN [KW_COUNT] = '{
        3, 5, 6, 6, 6, 6, 7, 7, 7, 8, 8, 9, 9, 9, 10, 10, 11, 11
    };

    function automatic logic [5:0] punct_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            "=":     k = 6'd2;
            "+":     k = 6'd3;
            "-":     k = 6'd4;
            "*":     k = 6'd5;
            ",":     k = 6'd6;
            ";":     k = 6'd7;
            "{":     k = 6'd8;
            "}":     k = 6'd9;
            "(":     k = 6'd10;
            ")":     k = 6'd11;
            "[":     k = 6'd12;
            "]":     k = 6'd13;
            ".":     k = 6'd14;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_decimal(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_name_start(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
    endfunction

    function automatic logic is_eol(input logic [7:0] b);
        return (b == 8'h0D) || (b == 8'h0A);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == " ") || (b == 8'h09) || is_eol(b);
    endfunction

endpackage

// File: design/sts_src_if.sv
// ----------------------------------------------------------------------------
// sts_src_if: source byte channel
// Valid/ready channel carrying one source byte or the end marker.
// ----------------------------------------------------------------------------
interface sts_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;
    logic       end_of_input;

    modport source (output valid, output byte_req, output end_of_input, input ready);
    modport sink (input valid, input byte_req, input end_of_input, output ready);
endinterface

// File: design/sts_tok_if.sv
// ----------------------------------------------------------------------------
// sts_tok_if: token channel
// Valid/ready channel carrying one token result.
// ----------------------------------------------------------------------------
interface sts_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic [10:0] text_length;
    logic [1:0]  fault;
    logic        last_result;

    modport source (
        output valid, output kind, output start_offset, output end_offset,
        output text_length, output fault, output last_result, input ready
    );
    modport sink (
        input valid, input kind, input start_offset, input end_offset,
        input text_length, input fault, input last_result, output ready
    );
endinterface

// File: design/source_token_scanner.sv
// ----------------------------------------------------------------------------
// source_token_scanner: streaming lexical scanner with keyword table
// Scans source bytes into tokens (punctuators, comments, integers, names and
// keywords) and queues up to two tokens per byte for the token channel.
// ----------------------------------------------------------------------------
//  channel  | dir | transfer moves
//  ---------+-----+----------------------------------------------------------
//  src      | in  | one source byte, or the end marker
//  tokens   | out | one token: kind, offsets, text length, fault, last flag
//
// A byte is scanned in the cycle of its transfer; its tokens land in a
// four-entry result queue and can leave from the next cycle on.
// One byte per cycle holds while tokens are taken and each byte yields at most
// one token; a byte that closes a token and adds a punctuator or error yields
// two, and the queue's single read port sets the pace. src.ready is high while
// the queue has room for two tokens. After reset bytes are taken at once.
// After an end, error or fault token, bytes are taken and dropped until reset.
// ----------------------------------------------------------------------------
module source_token_scanner #(
    parameter int unsigned MAX_TEXT_LENGTH = 1024,
    parameter int unsigned OFFSET_WIDTH    = 32
) (
    input logic      clk,
    input logic      rst_n,
    sts_src_if.sink  src,
    sts_tok_if.source tokens
);

    localparam int unsigned TCW = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int unsigned QPW = $clog2(sts_pkg::FIFO_DEPTH);
    localparam int unsigned QCW = $clog2(sts_pkg::FIFO_DEPTH + 1);
    localparam logic [TCW-1:0] TEXT_CAP = TCW'(MAX_TEXT_LENGTH);
    localparam logic [TCW-1:0] PFX_CAP  = TCW'(sts_pkg::PREFIX_DEPTH);

    function automatic logic [31:0] off_out(input logic [OFFSET_WIDTH-1:0] v);
        logic [OFFSET_WIDTH+31:0] e;
        e = {32'b0, v};
        return e[31:0];
    endfunction

    function automatic logic [10:0] len_out(input logic [TCW-1:0] v);
        logic [TCW+10:0] e;
        e = {11'b0, v};
        return e[10:0];
    endfunction

    function automatic sts_pkg::result_t make_result(
        input logic [5:0]              kind,
        input logic [OFFSET_WIDTH-1:0] start_pos,
        input logic [OFFSET_WIDTH-1:0] end_pos,
        input logic [TCW-1:0]          len,
        input logic [1:0]              fault
    );
        sts_pkg::result_t r;
        r.kind         = kind;
        r.start_offset = off_out(start_pos);
        r.end_offset   = off_out(end_pos);
        r.text_length  = len_out(len);
        r.fault        = fault;
        r.last_result  = 1'b0;
        return r;
    endfunction

    // Scanner state
    sts_pkg::mode_t          mode_reg, mode_next;
    logic                    halted_reg, halted_next;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [OFFSET_WIDTH-1:0] tstart_reg, tstart_next;
    logic [OFFSET_WIDTH-1:0] pend_reg, pend_next;
    logic [TCW-1:0]          tcount_reg, tcount_next;
    logic [7:0]              pfx_reg [sts_pkg::PREFIX_DEPTH];

    logic                    pfx_we;
    logic [sts_pkg::PIW-1:0] pfx_idx;

    // Result queue
    sts_pkg::result_t        fifo_reg [sts_pkg::FIFO_DEPTH];
    logic [QPW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]          cnt_reg, cnt_next;

    logic                    accept;
    logic                    pop;
    logic [1:0]              push_cnt;
    logic [7:0]              b;
    logic [OFFSET_WIDTH-1:0] pos_inc;
    logic [5:0]              name_kind;
    logic [5:0]              close_kind;
    logic [5:0]              pk;
    logic                    close_v, main_v;
    sts_pkg::result_t        close_r, main_r, res0, res1, head;

    assign accept  = src.valid && src.ready;
    assign pop     = tokens.valid && tokens.ready;
    assign b       = src.byte_req;
    assign pos_inc = pos_reg + OFFSET_WIDTH'(1);
    assign pk      = sts_pkg::punct_kind(b);

    // Keyword lookup over the saved prefix, all 18 words in parallel.
    always_comb
    begin
        logic hit;
        int   idx;
        name_kind = sts_pkg::KIND_NAME;
        for (int k = 0; k < sts_pkg::KW_COUNT; k++)
        begin
            hit = (tcount_reg == TCW'(sts_pkg::KW_LEN[k]));
            for (int j = 0; j < sts_pkg::PREFIX_DEPTH; j++)
            begin
                idx = (j < sts_pkg::KW_LEN[k]) ? (sts_pkg::KW_LEN[k] - 1 - j) : 0;
                if (j < sts_pkg::KW_LEN[k])
                begin
                    hit = hit && (pfx_reg[j] == sts_pkg::KW_TEXT[k][idx]);
                end
            end
            if (hit)
            begin
                name_kind = sts_pkg::KIND_FIRST_KW + 6'(k);
            end
        end
    end

    always_comb
    begin
        case (mode_reg)
            sts_pkg::MODE_INTEGER: close_kind = sts_pkg::KIND_INTEGER;
            sts_pkg::MODE_NAME:    close_kind = name_kind;
            default:               close_kind = sts_pkg::KIND_COMMENT;
        endcase
    end

    // One scan step for the byte in the current transfer.
    always_comb
    begin
        logic       do_close;
        logic       do_idle;
        logic       do_save;
        logic [1:0] flt;

        mode_next   = mode_reg;
        halted_next = halted_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        pend_next   = pend_reg;
        tcount_next = tcount_reg;
        pfx_we      = 1'b0;
        pfx_idx     = '0;
        close_v     = 1'b0;
        main_v      = 1'b0;
        close_r     = make_result(close_kind, tstart_reg, pos_reg, tcount_reg,
                                  sts_pkg::FAULT_NONE);
        main_r      = close_r;
        do_close    = 1'b0;
        do_idle     = 1'b0;
        do_save     = 1'b0;
        flt         = sts_pkg::FAULT_NONE;

        if (!halted_reg)
        begin
            if (src.end_of_input)
            begin
                main_v = 1'b1;
                if (mode_reg == sts_pkg::MODE_SLASH)
                begin
                    pend_next = pos_reg;
                    main_r    = make_result(sts_pkg::KIND_ERROR, tstart_reg, pos_reg,
                                            '0, sts_pkg::FAULT_NONE);
                end
                else
                begin
                    if (mode_reg != sts_pkg::MODE_IDLE)
                    begin
                        close_v   = 1'b1;
                        pend_next = pos_reg;
                    end
                    main_r = make_result(sts_pkg::KIND_END, tstart_reg, pos_reg,
                                         tcount_reg, sts_pkg::FAULT_NONE);
                end
                mode_next   = sts_pkg::MODE_IDLE;
                halted_next = 1'b1;
            end
            else
            begin
                unique case (mode_reg)
                    sts_pkg::MODE_SLASH:
                    begin
                        if (b == "/")
                        begin
                            pos_next  = pos_inc;
                            mode_next = sts_pkg::MODE_COMMENT;
                        end
                        else
                        begin
                            pend_next   = pos_reg;
                            main_v      = 1'b1;
                            main_r      = make_result(sts_pkg::KIND_ERROR, tstart_reg,
                                                      pos_reg, '0, sts_pkg::FAULT_NONE);
                            mode_next   = sts_pkg::MODE_IDLE;
                            halted_next = 1'b1;
                        end
                    end
                    sts_pkg::MODE_COMMENT:
                    begin
                        do_close = sts_pkg::is_eol(b);
                        do_save  = !sts_pkg::is_eol(b);
                    end
                    sts_pkg::MODE_INTEGER:
                    begin
                        do_save  = sts_pkg::is_decimal(b);
                        do_close = !sts_pkg::is_decimal(b);
                    end
                    sts_pkg::MODE_NAME:
                    begin
                        do_save  = sts_pkg::is_decimal(b) || sts_pkg::is_name_start(b);
                        do_close = !do_save;
                    end
                    default:
                    begin
                        do_idle = 1'b1;
                    end
                endcase

                if (do_close)
                begin
                    close_v   = 1'b1;
                    pend_next = pos_reg;
                    mode_next = sts_pkg::MODE_IDLE;
                    do_idle   = 1'b1;
                end

                if (do_idle)
                begin
                    if (sts_pkg::is_blank(b))
                    begin
                        pos_next = pos_inc;
                    end
                    else
                    begin
                        // A new token starts where the previous one ended.
                        tstart_next = pend_next;
                        tcount_next = '0;
                        if (pk != sts_pkg::KIND_NONE)
                        begin
                            pfx_we      = 1'b1;
                            tcount_next = TCW'(1);
                            pos_next    = pos_inc;
                            pend_next   = pos_inc;
                            main_v      = 1'b1;
                            main_r      = make_result(pk, tstart_next, pos_inc, TCW'(1),
                                                      sts_pkg::FAULT_NONE);
                        end
                        else if (b == "/")
                        begin
                            pos_next  = pos_inc;
                            mode_next = sts_pkg::MODE_SLASH;
                        end
                        else if (sts_pkg::is_decimal(b) || sts_pkg::is_name_start(b))
                        begin
                            pfx_we      = 1'b1;
                            tcount_next = TCW'(1);
                            pos_next    = pos_inc;
                            mode_next   = sts_pkg::is_decimal(b) ? sts_pkg::MODE_INTEGER
                                                                 : sts_pkg::MODE_NAME;
                        end
                        else
                        begin
                            main_v      = 1'b1;
                            main_r      = make_result(sts_pkg::KIND_ERROR, tstart_next,
                                                      pos_reg, '0, sts_pkg::FAULT_NONE);
                            pend_next   = pos_reg;
                            halted_next = 1'b1;
                        end
                    end
                end

                if (do_save)
                begin
                    if ((mode_reg == sts_pkg::MODE_COMMENT) && (b == 8'h00))
                    begin
                        flt = sts_pkg::FAULT_NUL;
                    end
                    else if (tcount_reg >= TEXT_CAP)
                    begin
                        flt = sts_pkg::FAULT_CAPACITY;
                    end

                    if (flt != sts_pkg::FAULT_NONE)
                    begin
                        main_v      = 1'b1;
                        main_r      = make_result(sts_pkg::KIND_ERROR, tstart_reg, pos_reg,
                                                  tcount_reg, flt);
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        pfx_we      = (tcount_reg < PFX_CAP);
                        pfx_idx     = tcount_reg[sts_pkg::PIW-1:0];
                        tcount_next = tcount_reg + TCW'(1);
                        pos_next    = pos_inc;
                    end
                end
            end
        end
    end

    always_comb
    begin
        res0             = close_v ? close_r : main_r;
        res0.last_result = !(close_v && main_v);
        res1             = main_r;
        res1.last_result = 1'b1;
        push_cnt         = accept ? ({1'b0, close_v} + {1'b0, main_v}) : 2'd0;
        wr_ptr_next      = wr_ptr_reg + QPW'(push_cnt);
        rd_ptr_next      = rd_ptr_reg + QPW'(pop);
        cnt_next         = cnt_reg + QCW'(push_cnt) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sts_pkg::MODE_IDLE;
            halted_reg <= 1'b0;
            pos_reg    <= '0;
            tstart_reg <= '0;
            pend_reg   <= '0;
            tcount_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                halted_reg <= halted_next;
                pos_reg    <= pos_next;
                tstart_reg <= tstart_next;
                pend_reg   <= pend_next;
                tcount_reg <= tcount_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pfx_we)
        begin
            pfx_reg[pfx_idx] <= b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + QPW'(1)] <= res1;
        end
    end

    assign head = fifo_reg[rd_ptr_reg];

    assign src.ready           = (cnt_reg <= QCW'(sts_pkg::FIFO_DEPTH - 2));
    assign tokens.valid        = (cnt_reg != '0);
    assign tokens.kind         = head.kind;
    assign tokens.start_offset = head.start_offset;
    assign tokens.end_offset   = head.end_offset;
    assign tokens.text_length  = head.text_length;
    assign tokens.fault        = head.fault;
    assign tokens.last_result  = head.last_result;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCW'(sts_pkg::FIFO_DEPTH))
        else $error("result queue holds more tokens than its depth");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (push_cnt == 2'd0))
        else $error("token produced while the scanner is halted");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted scanner resumed without reset");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |=> tokens.valid)
        else $error("queued token not presented on the token channel");
`endif

endmodule
